// File: sv/rap_pkg.sv
// Shared definitions for the rate average and peak hold block.
// Holds widths, register codes, reset values and the configuration struct.
// Used by rap_apb_regs and rate_average_peak_hold; depends on nothing.
package rap_pkg;

    localparam int WINDOW_LEN    = 10;
    localparam int HISTORY_DEPTH = 64;

    localparam int RATE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int SUM_W   = 12;
    localparam int HOLD_W  = 17;
    localparam int TICKS_W = 16;
    localparam int POS_W   = $clog2(WINDOW_LEN);
    localparam int PTR_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);

    // The average is the sum times a rounded-up reciprocal of the window length.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] AVG_RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + WINDOW_LEN - 1) / WINDOW_LEN);
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd2;

    localparam logic               ENABLE_RST        = 1'b1;
    localparam logic [TICKS_W-1:0] HOLD_TICKS_RST    = 16'd10000;
    localparam logic [TICKS_W-1:0] SAMPLE_PERIOD_RST = 16'd100;

    typedef struct packed {
        logic               enable;
        logic [TICKS_W-1:0] hold_ticks;
        logic [TICKS_W-1:0] sample_period;
    } rap_cfg_t;

endpackage

// File: sv/rap_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no other dependencies.
module rap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/rap_apb_regs.sv
// APB register file for the rate average and peak hold block.
// Depends on rap_pkg for register codes, reset values and the config struct.
module rap_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rap_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rap_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rap_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output rap_pkg::rap_cfg_t                cfg
);

    rap_pkg::rap_cfg_t                  cfg_reg;
    logic [rap_pkg::REG_IDX_W-1:0]      reg_idx;
    logic                               wr_en;

    assign reg_idx = paddr[rap_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= rap_pkg::ENABLE_RST;
            cfg_reg.hold_ticks    <= rap_pkg::HOLD_TICKS_RST;
            cfg_reg.sample_period <= rap_pkg::SAMPLE_PERIOD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                rap_pkg::REG_ENABLE:
                begin
                    cfg_reg.enable <= pwdata[0];
                end
                rap_pkg::REG_HOLD_TICKS:
                begin
                    cfg_reg.hold_ticks <= pwdata[rap_pkg::TICKS_W-1:0];
                end
                rap_pkg::REG_SAMPLE_PERIOD:
                begin
                    cfg_reg.sample_period <= pwdata[rap_pkg::TICKS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            rap_pkg::REG_ENABLE:
                prdata = {{(rap_pkg::APB_DATA_W-1){1'b0}}, cfg_reg.enable};
            rap_pkg::REG_HOLD_TICKS:
                prdata = {{(rap_pkg::APB_DATA_W-rap_pkg::TICKS_W){1'b0}},
                          cfg_reg.hold_ticks};
            rap_pkg::REG_SAMPLE_PERIOD:
                prdata = {{(rap_pkg::APB_DATA_W-rap_pkg::TICKS_W){1'b0}},
                          cfg_reg.sample_period};
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: sv/rate_average_peak_hold.sv
// Top level of the rate average and peak hold block.
// Depends on rap_pkg, rap_apb_regs and rap_ram.
//
// Each transfer on the tick channel (tick_valid/tick_ready) carries one
// millisecond's current_rate and the history_index to report. Each tick gives
// exactly one transfer on the result channel (result_valid/result_ready) with
// the moving average, the held peak, the sampled flag and the history entry
// at history_index as it stands after that tick.
// A tick is registered in the input stage at its transfer and processed when
// it advances into the result register, when the state update, the history
// write and the history read happen together.
// The block takes one tick per cycle: the result register frees itself in
// the cycle it is taken, and the input stage advances whenever the result
// register is empty or being taken. When the receiver stalls, the result
// holds, the registered tick waits, and tick_ready drops once both are full.
// The history is a 64-entry RAM used as a circular buffer with a fill count,
// so reset takes effect at once: all state reads as zero and the
// configuration registers return to enable 1, hold 10000, sample period 100.
// Configuration must be written through the APB port while no tick is in flight; the block does not enforce it.
module rate_average_peak_hold (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rap_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [rap_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [rap_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              tick_valid,
    output logic                              tick_ready,
    input  logic [rap_pkg::RATE_W-1:0]        current_rate,
    input  logic [rap_pkg::INDEX_W-1:0]       history_index,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [rap_pkg::RATE_W-1:0]        average_rate,
    output logic [rap_pkg::RATE_W-1:0]        peak_rate,
    output logic                              sampled,
    output logic [rap_pkg::RATE_W-1:0]        history_value
);

    rap_pkg::rap_cfg_t cfg;

    logic                             s1_valid_reg;
    logic [rap_pkg::RATE_W-1:0]       s1_rate_reg;
    logic [rap_pkg::INDEX_W-1:0]      s1_index_reg;

    logic                             out_valid_reg;
    logic                             sampled_reg;
    logic                             hist_zero_reg;
    logic                             hist_bypass_reg;

    logic [rap_pkg::RATE_W-1:0]       ring_reg [rap_pkg::WINDOW_LEN];
    logic [rap_pkg::POS_W-1:0]        ring_pos_reg;
    logic [rap_pkg::SUM_W-1:0]        ring_sum_reg;
    logic [rap_pkg::RATE_W-1:0]       avg_reg;
    logic [rap_pkg::RATE_W-1:0]       peak_reg;
    logic [rap_pkg::HOLD_W-1:0]       hold_cnt_reg;
    logic [rap_pkg::TICKS_W-1:0]      period_cnt_reg;
    logic [rap_pkg::PTR_W-1:0]        wptr_reg;
    logic [rap_pkg::CNT_W-1:0]        hist_cnt_reg;

    logic                             s1_adv;
    logic                             take;
    logic                             do_sample;
    logic                             do_push;
    logic [rap_pkg::HOLD_W-1:0]       hold_inc;
    logic [rap_pkg::TICKS_W-1:0]      period_inc;
    logic                             rise;
    logic                             follow;
    logic [rap_pkg::RATE_W-1:0]       peak_next;
    logic [rap_pkg::HOLD_W-1:0]       hold_next;
    logic                             sample_due;
    logic [rap_pkg::TICKS_W-1:0]      period_next;
    logic [rap_pkg::RATE_W-1:0]       ring_old;
    logic [rap_pkg::SUM_W-1:0]        sum_next;
    logic [rap_pkg::PROD_W-1:0]       avg_prod;
    logic [rap_pkg::RATE_W-1:0]       avg_next;
    logic [rap_pkg::POS_W-1:0]        pos_next;
    logic [rap_pkg::CNT_W-1:0]        hist_cnt_next;
    logic [rap_pkg::PTR_W-1:0]        wptr_next;
    logic [rap_pkg::PTR_W-1:0]        newest_ptr;
    int                               hist_addr_int;
    logic [rap_pkg::PTR_W-1:0]        hist_raddr;
    logic                             hist_zero;
    logic                             hist_bypass;
    logic [rap_pkg::RATE_W-1:0]       ram_rdata;

    rap_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result_ready);
    assign tick_ready = !s1_valid_reg || s1_adv;
    assign take       = s1_adv && cfg.enable;
    assign do_sample  = take && sample_due;
    assign do_push    = do_sample && (pos_next == rap_pkg::POS_W'(rap_pkg::WINDOW_LEN - 1));

    always_comb
    begin
        hold_inc   = (hold_cnt_reg == '1) ? hold_cnt_reg : hold_cnt_reg + 1'b1;
        period_inc = (period_cnt_reg == '1) ? period_cnt_reg : period_cnt_reg + 1'b1;

        rise      = peak_reg < s1_rate_reg;
        follow    = hold_inc > {1'b0, cfg.hold_ticks};
        peak_next = (rise || follow) ? s1_rate_reg : peak_reg;
        hold_next = rise ? '0 : hold_inc;

        sample_due  = period_inc >= cfg.sample_period;
        period_next = sample_due ? '0 : period_inc;

        ring_old = ring_reg[ring_pos_reg];
        sum_next = ring_sum_reg - rap_pkg::SUM_W'(ring_old)
                   + rap_pkg::SUM_W'(s1_rate_reg);
        avg_prod = rap_pkg::PROD_W'(sum_next) * rap_pkg::PROD_W'(rap_pkg::AVG_RECIP);
        avg_next = rap_pkg::RATE_W'(avg_prod >> rap_pkg::RECIP_SHIFT);
        pos_next = (ring_pos_reg == rap_pkg::POS_W'(rap_pkg::WINDOW_LEN - 1)) ?
                   '0 : ring_pos_reg + 1'b1;
    end

    // The history is a circular buffer: wptr_reg is the next slot to write.
    always_comb
    begin
        wptr_next = (wptr_reg == rap_pkg::PTR_W'(rap_pkg::HISTORY_DEPTH - 1)) ?
                    '0 : wptr_reg + 1'b1;
        if (do_push && (hist_cnt_reg != rap_pkg::CNT_W'(rap_pkg::HISTORY_DEPTH)))
        begin
            hist_cnt_next = hist_cnt_reg + 1'b1;
        end
        else
        begin
            hist_cnt_next = hist_cnt_reg;
        end
        if (do_push)
        begin
            newest_ptr = wptr_reg;
        end
        else if (wptr_reg == '0)
        begin
            newest_ptr = rap_pkg::PTR_W'(rap_pkg::HISTORY_DEPTH - 1);
        end
        else
        begin
            newest_ptr = wptr_reg - 1'b1;
        end
        hist_addr_int = int'(newest_ptr) - int'(s1_index_reg);
        if (hist_addr_int < 0)
        begin
            hist_addr_int = hist_addr_int + rap_pkg::HISTORY_DEPTH;
        end
        hist_raddr  = rap_pkg::PTR_W'(hist_addr_int);
        hist_zero   = !(int'(s1_index_reg) < int'(hist_cnt_next));
        hist_bypass = do_push && (s1_index_reg == '0);
    end

    rap_ram #(
        .WIDTH (rap_pkg::RATE_W),
        .DEPTH (rap_pkg::HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (do_push),
        .waddr (wptr_reg),
        .wdata (avg_next),
        .re    (s1_adv),
        .raddr (hist_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (tick_ready)
        begin
            s1_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_ready && tick_valid)
        begin
            s1_rate_reg  <= current_rate;
            s1_index_reg <= history_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            sampled_reg     <= 1'b0;
            hist_zero_reg   <= 1'b1;
            hist_bypass_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg   <= 1'b1;
            sampled_reg     <= do_sample;
            hist_zero_reg   <= hist_zero;
            hist_bypass_reg <= hist_bypass;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rap_pkg::WINDOW_LEN; i++)
            begin
                ring_reg[i] <= '0;
            end
            ring_pos_reg   <= '0;
            ring_sum_reg   <= '0;
            avg_reg        <= '0;
            peak_reg       <= '0;
            hold_cnt_reg   <= '0;
            period_cnt_reg <= '0;
            wptr_reg       <= '0;
            hist_cnt_reg   <= '0;
        end
        else if (take)
        begin
            peak_reg       <= peak_next;
            hold_cnt_reg   <= hold_next;
            period_cnt_reg <= period_next;
            if (sample_due)
            begin
                ring_reg[ring_pos_reg] <= s1_rate_reg;
                ring_pos_reg           <= pos_next;
                ring_sum_reg           <= sum_next;
                avg_reg                <= avg_next;
            end
            if (do_push)
            begin
                wptr_reg     <= wptr_next;
                hist_cnt_reg <= hist_cnt_next;
            end
        end
    end

    assign result_valid  = out_valid_reg;
    assign average_rate  = avg_reg;
    assign peak_rate     = peak_reg;
    assign sampled       = sampled_reg;
    assign history_value = hist_zero_reg ? '0 : (hist_bypass_reg ? avg_reg : ram_rdata);

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> tick_ready)
        else $error("Tick channel stalled while the result register is empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        hist_cnt_reg <= rap_pkg::CNT_W'(rap_pkg::HISTORY_DEPTH))
        else $error("History fill count exceeds the history depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ring_pos_reg < rap_pkg::POS_W'(rap_pkg::WINDOW_LEN))
        else $error("Ring position is outside the window.");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_sample |=> (period_cnt_reg == '0) && sampled_reg)
        else $error("A sample did not restart the period counter.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && rise) |=> (hold_cnt_reg == '0) && (peak_reg == $past(s1_rate_reg)))
        else $error("A peak rise did not load the peak and clear the hold counter.");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for rate_average_peak_hold: drives ticks and APB register writes,
// predicts every result with a local model of the block and compares each field.
// Depends on rap_pkg and the rate_average_peak_hold RTL.
module tb;
    import rap_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 4;
    localparam logic [HOLD_W-1:0]  HOLD_CNT_MAX   = '1;
    localparam logic [TICKS_W-1:0] PERIOD_CNT_MAX = '1;

    typedef struct packed {
        logic [RATE_W-1:0] average_rate;
        logic [RATE_W-1:0] peak_rate;
        logic              sampled;
        logic [RATE_W-1:0] history_value;
    } rate_report_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  tick_valid    = 1'b0;
    logic                  tick_ready;
    logic [RATE_W-1:0]     current_rate  = '0;
    logic [INDEX_W-1:0]    history_index = '0;
    logic                  result_valid;
    logic                  result_ready  = 1'b0;
    logic [RATE_W-1:0]     average_rate;
    logic [RATE_W-1:0]     peak_rate;
    logic                  sampled;
    logic [RATE_W-1:0]     history_value;

    rap_cfg_t           model_cfg;
    logic [RATE_W-1:0]  ring_slots [WINDOW_LEN];
    logic [POS_W-1:0]   ring_pos;
    logic [SUM_W-1:0]   ring_total;
    logic [RATE_W-1:0]  avg_now;
    logic [RATE_W-1:0]  peak_now;
    logic [HOLD_W-1:0]  since_rise;
    logic [TICKS_W-1:0] since_sample;
    logic [RATE_W-1:0]  history_line [HISTORY_DEPTH];

    rate_report_t rate_reports_due [$];
    int           mismatches        = 0;
    int           send_idle_pct     = 0;
    int           recv_stall_pct    = 0;
    int unsigned  hold_off_requests = 0;
    int unsigned  hold_offs_served  = 0;
    int unsigned  hold_off_left     = 0;
    int unsigned  quiet_cycles      = 0;
    logic [RATE_W-1:0] last_rate    = '0;

    rate_average_peak_hold dut (.*);

    always #HALF_PERIOD clk = ~clk;

    function automatic rate_report_t compute_rate_report(input logic [RATE_W-1:0]  rate,
                                                         input logic [INDEX_W-1:0] idx);
        rate_report_t report;
        logic         took;
        took = 1'b0;
        if (model_cfg.enable)
        begin
            if (since_rise != HOLD_CNT_MAX)
                since_rise = since_rise + 1'b1;
            if (since_sample != PERIOD_CNT_MAX)
                since_sample = since_sample + 1'b1;
            if (peak_now < rate)
            begin
                peak_now   = rate;
                since_rise = '0;
            end
            else if (since_rise > HOLD_W'(model_cfg.hold_ticks))
            begin
                peak_now = rate;
            end
            if (since_sample >= model_cfg.sample_period)
            begin
                ring_total = ring_total - SUM_W'(ring_slots[ring_pos]) + SUM_W'(rate);
                ring_slots[ring_pos] = rate;
                ring_pos = (ring_pos == POS_W'(WINDOW_LEN - 1)) ? '0 : ring_pos + 1'b1;
                avg_now = RATE_W'(ring_total / WINDOW_LEN);
                if (ring_pos == POS_W'(WINDOW_LEN - 1))
                begin
                    for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                        history_line[i] = history_line[i - 1];
                    history_line[0] = avg_now;
                end
                since_sample = '0;
                took = 1'b1;
            end
        end
        report.average_rate  = avg_now;
        report.peak_rate     = peak_now;
        report.sampled       = took;
        report.history_value = history_line[idx];
        return report;
    endfunction

    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:        model_cfg.enable        = value[0];
            REG_HOLD_TICKS:    model_cfg.hold_ticks    = value[TICKS_W-1:0];
            REG_SAMPLE_PERIOD: model_cfg.sample_period = value[TICKS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("prdata of register %0d: expected %0d, got %0d", idx, want, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic en, input logic [TICKS_W-1:0] hold,
                              input logic [TICKS_W-1:0] period);
        write_register(REG_ENABLE, APB_DATA_W'(en));
        write_register(REG_HOLD_TICKS, APB_DATA_W'(hold));
        write_register(REG_SAMPLE_PERIOD, APB_DATA_W'(period));
    endtask

    task automatic send_tick(input logic [RATE_W-1:0] rate, input logic [INDEX_W-1:0] idx);
        if ($urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        tick_valid    <= 1'b1;
        current_rate  <= rate;
        history_index <= idx;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        rate_reports_due.push_back(compute_rate_report(rate, idx));
    endtask

    task automatic wait_for_reports;
        tick_valid <= 1'b0;
        while (rate_reports_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic test_register_access;
        check_register(REG_ENABLE, APB_DATA_W'(ENABLE_RST));
        check_register(REG_HOLD_TICKS, APB_DATA_W'(HOLD_TICKS_RST));
        check_register(REG_SAMPLE_PERIOD, APB_DATA_W'(SAMPLE_PERIOD_RST));
        set_config(1'b1, 16'd1234, 16'd77);
        check_register(REG_ENABLE, 32'd1);
        check_register(REG_HOLD_TICKS, 32'd1234);
        check_register(REG_SAMPLE_PERIOD, 32'd77);
    endtask

    // Zero hold time and zero sample period: every tick samples and the peak decays quickly.
    task automatic test_directed_cases;
        set_config(1'b1, 16'd0, 16'd0);
        send_tick(8'd0, 6'd0);
        send_tick(8'd255, 6'd63);
        send_tick(8'd0, 6'd0);
        send_tick(8'd0, 6'd1);
        send_tick(8'hAA, 6'h2A);
        send_tick(8'h55, 6'h15);
        send_tick(8'd1, 6'd0);
        send_tick(8'd128, 6'd2);
        send_tick(8'd255, 6'd0);
        send_tick(8'd254, 6'd63);
        send_tick(8'd3, 6'd5);
        send_tick(8'd0, 6'd0);
        for (int i = 0; i < 10; i++)
            send_tick(RATE_W'(25 * i + 5), INDEX_W'(i % 3));
        wait_for_reports();
    endtask

    task automatic test_disabled_ticks;
        write_register(REG_ENABLE, 32'd0);
        send_tick(8'd255, 6'd0);
        send_tick(8'd7, 6'd63);
        send_tick(8'd0, 6'd1);
        wait_for_reports();
        write_register(REG_ENABLE, 32'd1);
    endtask

    // Largest hold time and sample period: the peak holds and no sample falls due.
    task automatic test_counter_limits;
        set_config(1'b1, 16'hFFFF, 16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_tick(8'd255, 6'd0);
        for (int i = 0; i < 100; i++)
            send_tick(RATE_W'($urandom_range(255)), INDEX_W'($urandom_range(63)));
        wait_for_reports();
    endtask

    task automatic test_backpressure;
        set_config(1'b1, 16'd5, 16'd1);
        hold_off_requests++;
        for (int i = 0; i < 40; i++)
            send_tick(RATE_W'($urandom_range(255)), INDEX_W'($urandom_range(63)));
        wait_for_reports();
    endtask

    task automatic test_random_traffic;
        int                 idle_of_phase  [4] = '{0, 85, 0, 7};
        int                 stall_of_phase [4] = '{0, 0, 85, 7};
        logic               en;
        logic [TICKS_W-1:0] hold;
        logic [TICKS_W-1:0] period;
        logic [RATE_W-1:0]  rate;
        logic [INDEX_W-1:0] idx;
        int                 count;
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = idle_of_phase[phase];
            recv_stall_pct = stall_of_phase[phase];
            for (int blk = 0; blk < 4; blk++)
            begin
                wait_for_reports();
                en = ($urandom_range(7) != 0);
                case ($urandom_range(3))
                    0:       hold = '0;
                    1:       hold = TICKS_W'($urandom_range(1, 20));
                    2:       hold = TICKS_W'($urandom_range(21, 200));
                    default: hold = TICKS_W'($urandom_range(65535));
                endcase
                case ($urandom_range(3))
                    0:       period = '0;
                    1:       period = 16'd1;
                    2:       period = TICKS_W'($urandom_range(2, 5));
                    default: period = TICKS_W'($urandom_range(6, 40));
                endcase
                set_config(en, hold, period);
                count = en ? 100 : 20;
                for (int i = 0; i < count; i++)
                begin
                    case ($urandom_range(3))
                        0:       rate = RATE_W'($urandom_range(255));
                        1:       rate = RATE_W'($urandom_range(15));
                        2:       rate = last_rate + RATE_W'($urandom_range(6)) - 8'd3;
                        default: rate = last_rate;
                    endcase
                    last_rate = rate;
                    idx = ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(63))
                                                   : INDEX_W'($urandom_range(7));
                    send_tick(rate, idx);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_off_requests != hold_offs_served)
        begin
            hold_offs_served <= hold_off_requests;
            hold_off_left    <= HOLD_OFF_CYCLES;
            result_ready     <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left <= hold_off_left - 1;
            result_ready  <= 1'b0;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        rate_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (rate_reports_due.size() == 0)
            begin
                $error("result transfer with no tick outstanding");
                mismatches++;
            end
            else
            begin
                want = rate_reports_due.pop_front();
                if (average_rate !== want.average_rate)
                begin
                    $error("average_rate: expected %0d, got %0d", want.average_rate,
                           average_rate);
                    mismatches++;
                end
                if (peak_rate !== want.peak_rate)
                begin
                    $error("peak_rate: expected %0d, got %0d", want.peak_rate, peak_rate);
                    mismatches++;
                end
                if (sampled !== want.sampled)
                begin
                    $error("sampled: expected %0d, got %0d", want.sampled, sampled);
                    mismatches++;
                end
                if (history_value !== want.history_value)
                begin
                    $error("history_value: expected %0d, got %0d", want.history_value,
                           history_value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (tick_valid && tick_ready) || (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        model_cfg    = {ENABLE_RST, HOLD_TICKS_RST, SAMPLE_PERIOD_RST};
        ring_pos     = '0;
        ring_total   = '0;
        avg_now      = '0;
        peak_now     = '0;
        since_rise   = '0;
        since_sample = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
            ring_slots[i] = '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            history_line[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_cases();
        test_disabled_ticks();
        test_counter_limits();
        test_backpressure();
        test_random_traffic();
        wait_for_reports();
        if (mismatches == 0 && rate_reports_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: rate_average_peak_hold.f
sv/rap_pkg.sv
sv/rap_ram.sv
sv/rap_apb_regs.sv
sv/rate_average_peak_hold.sv
sim/tb.sv
